/* design/tcw_pkg.sv */
// shared types, constants and helpers for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int CELL_W  = 16;
   localparam int OROW_W  = 5;
   localparam int OCOL_W  = 7;

   localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'h20;
   localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_B       = 8'h42;
   localparam logic [BYTE_W-1:0] CHAR_U       = 8'h55;
   localparam logic [BYTE_W-1:0] CHAR_G       = 8'h47;
   localparam logic [BYTE_W-1:0] ALARM_ATTR   = 8'h04;
   localparam logic [BYTE_W-1:0] RESET_COLOR  = 8'h07;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT_CHAR = 2'd0,
      CMD_PUT_CELL = 2'd1,
      CMD_SCROLL   = 2'd2,
      CMD_READ     = 2'd3
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic take_read;
      logic bug_step;
      logic copy_step;
      logic fill_step;
      logic fill_reset;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic go_read;
      logic go_bug;
      logic go_copy;
      logic go_fill;
      logic copy_done;
      logic fill_done;
      logic bug_done;
   } dp_status_type;

   // red error marker written into the first three cells
   function automatic logic [CELL_W-1:0] bug_cell(input logic [1:0] idx);
      logic [CELL_W-1:0] marker;
      case (idx)
         2'd0: begin
            marker = {ALARM_ATTR, CHAR_B};
         end
         2'd1: begin
            marker = {ALARM_ATTR, CHAR_U};
         end
         default: begin
            marker = {ALARM_ATTR, CHAR_G};
         end
      endcase
      return marker;
   endfunction

endpackage

/* design/tcw_if.sv */
// request, response and register-write channel interfaces
`timescale 1ns / 1ps

interface tcw_req_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] char_code;
   logic [BYTE_W-1:0] cell_color;
   logic [BYTE_W-1:0] target_column;
   logic [BYTE_W-1:0] target_row;
   logic [BYTE_W-1:0] scroll_count;

   modport source (output valid, command, char_code, cell_color, target_column,
                   target_row, scroll_count, input ready);
   modport sink (input valid, command, char_code, cell_color, target_column,
                 target_row, scroll_count, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_data;
   logic [OROW_W-1:0] current_row;
   logic [OCOL_W-1:0] current_column;
   logic              bounds_error;

   modport source (output valid, cell_data, current_row, current_column, bounds_error,
                   input ready);
   modport sink (input valid, cell_data, current_row, current_column, bounds_error,
                 output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_color;

   modport source (output valid, text_color, input ready);
   modport sink (input valid, text_color, output ready);
endinterface

/* design/text_console_writer_top.sv */
// top level of the text console writer
//
//   channel  dir  handshake      payload
//   req_if   in   valid / ready  command, char_code, cell_color, target_column,
//                                target_row, scroll_count
//   rsp_if   out  valid / ready  cell_data, current_row, current_column, bounds_error
//   csr_if   in   valid / ready  text_color (always ready)
//
// put character without scroll, put cell on screen, scroll by zero and off-screen read
// respond straight from idle; an on-screen read waits on the registered memory read and an
// off-screen put cell on the marker writes; a scroll by n < ROWS (a newline or wrap on the
// bottom row is n = 1) copies the kept rows up, then fills n rows; n >= ROWS fills every row
// after reset a clearing pass over every cell holds req ready low
// a stalled response sits in the output register; one more request may be taken meanwhile
`timescale 1ns / 1ps

module text_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic      clock,
   input  logic      reset,
   tcw_req_if.sink   req_if,
   tcw_rsp_if.source rsp_if,
   tcw_csr_if.sink   csr_if
);
   import tcw_pkg::*;

   dp_cmd_type    ctl;
   dp_status_type stat;
   logic          csr_we;

   assign csr_if.ready = 1'b1;
   assign csr_we       = csr_if.valid && csr_if.ready;

   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .command        (req_if.command),
      .char_code      (req_if.char_code),
      .cell_color     (req_if.cell_color),
      .target_column  (req_if.target_column),
      .target_row     (req_if.target_row),
      .scroll_count   (req_if.scroll_count),
      .csr_we         (csr_we),
      .csr_text_color (csr_if.text_color),
      .cell_data      (rsp_if.cell_data),
      .current_row    (rsp_if.current_row),
      .current_column (rsp_if.current_column),
      .bounds_error   (rsp_if.bounds_error)
   );

endmodule

/* design/tcw_datapath.sv */
// screen memory, cursor, sweep counters and response register
`timescale 1ns / 1ps

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::dp_cmd_type           ctl,
   output tcw_pkg::dp_status_type        stat,
   input  logic [tcw_pkg::CMD_W-1:0]     command,
   input  logic [tcw_pkg::BYTE_W-1:0]    char_code,
   input  logic [tcw_pkg::BYTE_W-1:0]    cell_color,
   input  logic [tcw_pkg::BYTE_W-1:0]    target_column,
   input  logic [tcw_pkg::BYTE_W-1:0]    target_row,
   input  logic [tcw_pkg::BYTE_W-1:0]    scroll_count,
   input  logic                          csr_we,
   input  logic [tcw_pkg::BYTE_W-1:0]    csr_text_color,
   output logic [tcw_pkg::CELL_W-1:0]    cell_data,
   output logic [tcw_pkg::OROW_W-1:0]    current_row,
   output logic [tcw_pkg::OCOL_W-1:0]    current_column,
   output logic                          bounds_error
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);

   localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
   localparam logic [AW-1:0] ROWS_A   = AW'(ROWS);
   localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
   localparam logic [AW-1:0] BUG_LAST = AW'(2);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [8:0]    COL_LIM  = 9'(COLUMNS);
   localparam logic [8:0]    ROW_LIM  = 9'(ROWS);

   logic [CELL_W-1:0] screen_mem [CELLS];

   logic [RW-1:0]     cursor_row_ff, cursor_row_in;
   logic [CW-1:0]     cursor_col_ff, cursor_col_in;
   logic [BYTE_W-1:0] text_color_ff, text_color_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic              wpend_ff, wpend_in;
   logic [AW-1:0]     off_ff, off_in;
   logic [AW-1:0]     keep_ff, keep_in;
   logic              err_ff, err_in;
   logic [CELL_W-1:0] data_ff, data_in;
   logic [CELL_W-1:0] rd_data_ff;
   logic [CELL_W-1:0] cell_data_ff;
   logic [OROW_W-1:0] row_out_ff;
   logic [OCOL_W-1:0] col_out_ff;
   logic              err_out_ff;

   cmd_type           cmd;
   logic              is_newline;
   logic              on_screen;
   logic              at_last_row;
   logic              at_last_col;
   logic              scroll_req;
   logic [BYTE_W-1:0] scroll_n;
   logic              n_big;
   logic [RW-1:0]     n_r;
   logic [AW-1:0]     tgt_addr;
   logic [AW-1:0]     cur_addr;
   logic              copy_done;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [CELL_W-1:0] wdata;
   logic              rd_en;
   logic [AW-1:0]     raddr;

   assign cmd         = cmd_type'(command);
   assign is_newline  = (char_code == NEWLINE_CHAR);
   assign on_screen   = ({1'b0, target_column} < COL_LIM) && ({1'b0, target_row} < ROW_LIM);
   assign at_last_row = (cursor_row_ff == LAST_ROW);
   assign at_last_col = (cursor_col_ff == LAST_COL);
   assign tgt_addr    = AW'(AW'(target_row[RW-1:0]) * COLS_A) + AW'(target_column[CW-1:0]);
   assign cur_addr    = AW'(AW'(cursor_row_ff) * COLS_A) + AW'(cursor_col_ff);

   // a newline or wrap on the bottom row scrolls by one
   assign scroll_req = (cmd == CMD_SCROLL) ||
                       ((cmd == CMD_PUT_CHAR) && at_last_row && (is_newline || at_last_col));
   assign scroll_n   = (cmd == CMD_SCROLL) ? scroll_count : 8'd1;
   assign n_big      = ({1'b0, scroll_n} >= ROW_LIM);
   assign n_r        = scroll_n[RW-1:0];
   assign copy_done  = (ptr_ff == keep_ff);

   always_comb begin
      stat.go_read   = (cmd == CMD_READ) && on_screen;
      stat.go_bug    = (cmd == CMD_PUT_CELL) && !on_screen;
      stat.go_copy   = scroll_req && (scroll_n != 8'd0) && !n_big;
      stat.go_fill   = scroll_req && n_big;
      stat.copy_done = copy_done;
      stat.fill_done = (ptr_ff == LAST_A);
      stat.bug_done  = (ptr_ff == BUG_LAST);
   end

   // cursor, text colour, error, data and scroll offset next values
   always_comb begin
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      err_in        = err_ff;
      data_in       = data_ff;
      text_color_in = csr_we ? csr_text_color : text_color_ff;
      off_in        = off_ff;
      keep_in       = keep_ff;
      if (ctl.accept) begin
         err_in  = ((cmd == CMD_PUT_CELL) || (cmd == CMD_READ)) && !on_screen;
         data_in = '0;
         off_in  = AW'(AW'(n_r) * COLS_A);
         keep_in = AW'((ROWS_A - AW'(n_r)) * COLS_A);
         if (cmd == CMD_PUT_CHAR) begin
            if (is_newline || at_last_col) begin
               cursor_col_in = '0;
               if (!at_last_row) begin
                  cursor_row_in = cursor_row_ff + RW'(1);
               end
            end else begin
               cursor_col_in = cursor_col_ff + CW'(1);
            end
         end
      end
      if (ctl.take_read) begin
         data_in = rd_data_ff;
      end
   end

   // sweep pointer
   always_comb begin
      ptr_in    = ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      wpend_in  = 1'b0;
      if (ctl.accept) begin
         ptr_in = stat.go_bug ? AW'(1) : '0;
      end else if (ctl.bug_step || ctl.fill_step) begin
         ptr_in = ptr_ff + AW'(1);
      end else if (ctl.copy_step && !copy_done) begin
         ptr_in    = ptr_ff + AW'(1);
         wr_ptr_in = ptr_ff;
         wpend_in  = 1'b1;
      end
   end

   // single write port
   always_comb begin
      we    = 1'b0;
      waddr = ptr_ff;
      wdata = {text_color_ff, SPACE_CHAR};
      if (ctl.accept) begin
         if ((cmd == CMD_PUT_CHAR) && !is_newline) begin
            we    = 1'b1;
            waddr = cur_addr;
            wdata = {text_color_ff, char_code};
         end else if (cmd == CMD_PUT_CELL) begin
            we = 1'b1;
            if (on_screen) begin
               waddr = tgt_addr;
               wdata = {cell_color, char_code};
            end else begin
               waddr = '0;
               wdata = bug_cell(2'd0);
            end
         end
      end else if (ctl.bug_step) begin
         we    = 1'b1;
         wdata = bug_cell(ptr_ff[1:0]);
      end else if (ctl.copy_step) begin
         we    = wpend_ff;
         waddr = wr_ptr_ff;
         wdata = rd_data_ff;
      end else if (ctl.fill_step) begin
         we    = 1'b1;
         wdata = ctl.fill_reset ? {RESET_COLOR, SPACE_CHAR} : {text_color_ff, SPACE_CHAR};
      end
   end

   assign rd_en = ctl.accept || (ctl.copy_step && !copy_done);
   assign raddr = ctl.accept ? tgt_addr : (ptr_ff + off_ff);

   always_ff @(posedge clock) begin
      if (we) begin
         screen_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= screen_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         text_color_ff <= RESET_COLOR;
         ptr_ff        <= '0;
         wpend_ff      <= 1'b0;
      end else begin
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         text_color_ff <= text_color_in;
         ptr_ff        <= ptr_in;
         wpend_ff      <= wpend_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff <= wr_ptr_in;
      off_ff    <= off_in;
      keep_ff   <= keep_in;
      err_ff    <= err_in;
      data_ff   <= data_in;
      if (ctl.load_rsp) begin
         cell_data_ff <= data_in;
         row_out_ff   <= OROW_W'(cursor_row_in);
         col_out_ff   <= OCOL_W'(cursor_col_in);
         err_out_ff   <= err_in;
      end
   end

   assign cell_data      = cell_data_ff;
   assign current_row    = row_out_ff;
   assign current_column = col_out_ff;
   assign bounds_error   = err_out_ff;

endmodule

/* design/tcw_controller.sv */
// command sequencer and response handshake for the text console writer
`timescale 1ns / 1ps

module tcw_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tcw_pkg::dp_status_type stat,
   output tcw_pkg::dp_cmd_type    ctl
);
   import tcw_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_BUG   = 7'b0001000,
      S_COPY  = 7'b0010000,
      S_FILL  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      ctl            = '0;
      ctl.accept     = accept;
      case (state_ff)
         S_CLEAR: begin
            ctl.fill_step  = 1'b1;
            ctl.fill_reset = 1'b1;
            if (stat.fill_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (stat.go_read) begin
                  state_in = S_READ;
               end else if (stat.go_bug) begin
                  state_in = S_BUG;
               end else if (stat.go_copy) begin
                  state_in = S_COPY;
               end else if (stat.go_fill) begin
                  state_in = S_FILL;
               end else if (out_free) begin
                  ctl.load_rsp = 1'b1;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_READ: begin
            ctl.take_read = 1'b1;
            ctl.load_rsp  = out_free;
            state_in      = out_free ? S_IDLE : S_EMIT;
         end
         S_BUG: begin
            ctl.bug_step = 1'b1;
            if (stat.bug_done) begin
               ctl.load_rsp = out_free;
               state_in     = out_free ? S_IDLE : S_EMIT;
            end
         end
         S_COPY: begin
            // last step only drains the pending write
            ctl.copy_step = 1'b1;
            if (stat.copy_done) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            ctl.fill_step = 1'b1;
            if (stat.fill_done) begin
               ctl.load_rsp = out_free;
               state_in     = out_free ? S_IDLE : S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* tb/sv/text_console_writer_top_tb.sv */
// self-checking testbench for the text console writer, predicted against a screen shadow
`timescale 1ns / 1ps

module text_console_writer_top_tb;
   import tcw_pkg::*;

   localparam int COLUMNS        = 80;
   localparam int ROWS           = 25;
   localparam int CELL_COUNT     = COLUMNS * ROWS;
   localparam int PHASES         = 6;
   localparam int BATCH_ITEMS    = 210;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 20;
   localparam int REPORT_CAP     = 40;

   typedef struct {
      cmd_type           command;
      logic [BYTE_W-1:0] char_code;
      logic [BYTE_W-1:0] cell_color;
      logic [BYTE_W-1:0] target_column;
      logic [BYTE_W-1:0] target_row;
      logic [BYTE_W-1:0] scroll_count;
   } console_req_type;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [OROW_W-1:0] current_row;
      logic [OCOL_W-1:0] current_column;
      logic              bounds_error;
   } console_reply_type;

   class screen_shadow_type;
      logic [CELL_W-1:0] cells [CELL_COUNT];
      int unsigned       cur_row;
      int unsigned       cur_col;
      logic [BYTE_W-1:0] color;
      console_reply_type awaited [$];
      int                errors;
      int                replies_seen;

      function new();
         int i;
         color = RESET_COLOR;
         cur_row = 0;
         cur_col = 0;
         errors = 0;
         replies_seen = 0;
         for (i = 0; i < CELL_COUNT; i++) begin
            cells[i] = {RESET_COLOR, SPACE_CHAR};
         end
      endfunction

      function void set_color(logic [BYTE_W-1:0] value);
         color = value;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void scroll_up(int unsigned n);
         logic [CELL_W-1:0] blank;
         int unsigned keep;
         int unsigned i;
         blank = {color, SPACE_CHAR};
         if (n == 0) begin
            return;
         end
         keep = (n >= ROWS) ? 0 : (ROWS - n) * COLUMNS;
         for (i = 0; i < keep; i++) begin
            cells[i] = cells[i + n * COLUMNS];
         end
         for (i = keep; i < CELL_COUNT; i++) begin
            cells[i] = blank;
         end
      endfunction

      function void put_char(logic [BYTE_W-1:0] ch);
         if (ch == NEWLINE_CHAR) begin
            if (cur_row >= ROWS - 1) begin
               scroll_up(1);
               cur_row = ROWS - 1;
            end else begin
               cur_row++;
            end
            cur_col = 0;
            return;
         end
         cells[cur_row * COLUMNS + cur_col] = {color, ch};
         cur_col++;
         if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
            // wrap off the bottom row scrolls and keeps the cursor there
            if (cur_row >= ROWS) begin
               cur_row = ROWS - 1;
               scroll_up(1);
            end
         end
      endfunction

      function void apply_command(console_req_type rq);
         console_reply_type want;
         bit                on_screen;
         int unsigned       spot;
         want = '0;
         on_screen = (rq.target_column < COLUMNS) && (rq.target_row < ROWS);
         spot = rq.target_row * COLUMNS + rq.target_column;
         case (rq.command)
            CMD_PUT_CHAR: begin
               put_char(rq.char_code);
            end
            CMD_PUT_CELL: begin
               if (on_screen) begin
                  cells[spot] = {rq.cell_color, rq.char_code};
               end else begin
                  cells[0] = {ALARM_ATTR, CHAR_B};
                  cells[1] = {ALARM_ATTR, CHAR_U};
                  cells[2] = {ALARM_ATTR, CHAR_G};
                  want.bounds_error = 1'b1;
               end
            end
            CMD_SCROLL: begin
               scroll_up(rq.scroll_count);
            end
            default: begin
               if (on_screen) begin
                  want.cell_data = cells[spot];
               end else begin
                  want.bounds_error = 1'b1;
               end
            end
         endcase
         want.current_row = OROW_W'(cur_row);
         want.current_column = OCOL_W'(cur_col);
         awaited.push_back(want);
      endfunction

      function void check_reply(console_reply_type got);
         console_reply_type want;
         replies_seen++;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP) begin
               $display("%0t ns: unexpected reply, got data %h row %0d col %0d err %0b",
                        $time, got.cell_data, got.current_row, got.current_column,
                        got.bounds_error);
            end
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP) begin
               $display("%0t ns: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                        $time, want.cell_data, want.current_row, want.current_column,
                        want.bounds_error, got.cell_data, got.current_row,
                        got.current_column, got.bounds_error);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();
   tcw_csr_if csr_if ();

   text_console_writer_top #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   screen_shadow_type shadow = new();
   bit                quiet_tail = 1'b0;
   int                stall_cycles = 0;
   console_reply_type observed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] rnd8();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic void pick_position(input bit off_screen,
                                         output logic [BYTE_W-1:0] col,
                                         output logic [BYTE_W-1:0] row);
      col = BYTE_W'($urandom_range(0, COLUMNS - 1));
      row = BYTE_W'($urandom_range(0, ROWS - 1));
      if (off_screen) begin
         case ($urandom_range(0, 2))
            0: begin
               col = BYTE_W'($urandom_range(COLUMNS, 255));
            end
            1: begin
               row = BYTE_W'($urandom_range(ROWS, 255));
            end
            default: begin
               col = BYTE_W'($urandom_range(COLUMNS, 255));
               row = BYTE_W'($urandom_range(ROWS, 255));
            end
         endcase
      end
   endfunction

   task automatic send_cmd(input cmd_type cmd, input logic [BYTE_W-1:0] ch,
                           input logic [BYTE_W-1:0] attr, input logic [BYTE_W-1:0] col,
                           input logic [BYTE_W-1:0] row, input logic [BYTE_W-1:0] cnt);
      console_req_type rq;
      rq = '{cmd, ch, attr, col, row, cnt};
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.command       <= cmd;
      req_if.char_code     <= ch;
      req_if.cell_color    <= attr;
      req_if.target_column <= col;
      req_if.target_row    <= row;
      req_if.scroll_count  <= cnt;
      do @(posedge clock); while (!req_if.ready);
      shadow.apply_command(rq);
   endtask

   // sender stops offering until every awaited reply is back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   task automatic write_color(input logic [BYTE_W-1:0] value);
      csr_if.valid      <= 1'b1;
      csr_if.text_color <= value;
      do @(posedge clock); while (!csr_if.ready);
      shadow.set_color(value);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic directed_checks();
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd0, 8'd0, rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), BYTE_W'(COLUMNS - 1), BYTE_W'(ROWS - 1), rnd8());
      send_cmd(CMD_PUT_CHAR, 8'h41, rnd8(), rnd8(), rnd8(), rnd8());
      send_cmd(CMD_PUT_CHAR, 8'hFF, rnd8(), rnd8(), rnd8(), rnd8());
      send_cmd(CMD_PUT_CHAR, 8'h00, rnd8(), rnd8(), rnd8(), rnd8());
      send_cmd(CMD_PUT_CHAR, NEWLINE_CHAR, rnd8(), rnd8(), rnd8(), rnd8());
      send_cmd(CMD_PUT_CELL, 8'hFF, 8'hFF, BYTE_W'(COLUMNS - 1), BYTE_W'(ROWS - 1), rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), BYTE_W'(COLUMNS - 1), BYTE_W'(ROWS - 1), rnd8());
      send_cmd(CMD_PUT_CELL, 8'h00, 8'h00, 8'd0, 8'd0, rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd0, 8'd0, rnd8());
      // off-screen write leaves the red marker in the first three cells
      send_cmd(CMD_PUT_CELL, rnd8(), rnd8(), BYTE_W'(COLUMNS), 8'd0, rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd0, 8'd0, rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd1, 8'd0, rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd2, 8'd0, rnd8());
      send_cmd(CMD_PUT_CELL, rnd8(), rnd8(), 8'd0, BYTE_W'(ROWS), rnd8());
      send_cmd(CMD_PUT_CELL, rnd8(), rnd8(), 8'd255, 8'd255, rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), BYTE_W'(COLUMNS), 8'd0, rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd0, BYTE_W'(ROWS), rnd8());
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd255, 8'd255, rnd8());
      send_cmd(CMD_SCROLL, rnd8(), rnd8(), rnd8(), rnd8(), 8'd0);
      send_cmd(CMD_READ, rnd8(), rnd8(), BYTE_W'(COLUMNS - 1), BYTE_W'(ROWS - 1), rnd8());
      send_cmd(CMD_SCROLL, rnd8(), rnd8(), rnd8(), rnd8(), 8'd1);
      send_cmd(CMD_READ, rnd8(), rnd8(), BYTE_W'(COLUMNS - 1), BYTE_W'(ROWS - 2), rnd8());
      send_cmd(CMD_SCROLL, rnd8(), rnd8(), rnd8(), rnd8(), BYTE_W'(ROWS));
      send_cmd(CMD_SCROLL, rnd8(), rnd8(), rnd8(), rnd8(), 8'd255);
      send_cmd(CMD_READ, rnd8(), rnd8(), 8'd0, 8'd0, rnd8());
   endtask

   task automatic random_batch(input int count);
      int                sent;
      int                kind;
      int                len;
      int                i;
      logic [BYTE_W-1:0] ch;
      logic [BYTE_W-1:0] col;
      logic [BYTE_W-1:0] row;
      logic [BYTE_W-1:0] cnt;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 99);
         len = 1;
         if (kind < 40) begin
            // short text with the odd line break
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
               ch = ($urandom_range(0, 11) == 0) ? NEWLINE_CHAR : rnd8();
               send_cmd(CMD_PUT_CHAR, ch, rnd8(), rnd8(), rnd8(), rnd8());
            end
         end else if (kind < 43) begin
            len = $urandom_range(1, ROWS + 1);
            for (i = 0; i < len; i++) begin
               send_cmd(CMD_PUT_CHAR, NEWLINE_CHAR, rnd8(), rnd8(), rnd8(), rnd8());
            end
         end else if (kind < 45) begin
            // a line long enough to wrap
            len = $urandom_range(COLUMNS, COLUMNS + 10);
            for (i = 0; i < len; i++) begin
               ch = rnd8();
               if (ch == NEWLINE_CHAR) begin
                  ch = SPACE_CHAR;
               end
               send_cmd(CMD_PUT_CHAR, ch, rnd8(), rnd8(), rnd8(), rnd8());
            end
         end else if (kind < 60) begin
            pick_position($urandom_range(0, 5) == 0, col, row);
            send_cmd(CMD_PUT_CELL, rnd8(), rnd8(), col, row, rnd8());
         end else if (kind < 96) begin
            pick_position($urandom_range(0, 7) == 0, col, row);
            if (row < ROWS && col < COLUMNS && $urandom_range(0, 1) == 0) begin
               row = BYTE_W'(shadow.cur_row);
            end
            send_cmd(CMD_READ, rnd8(), rnd8(), col, row, rnd8());
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  cnt = 8'd0;
               end
               2, 3, 4, 5: begin
                  cnt = BYTE_W'($urandom_range(1, 3));
               end
               6, 7: begin
                  cnt = BYTE_W'($urandom_range(4, ROWS - 1));
               end
               default: begin
                  cnt = BYTE_W'($urandom_range(ROWS, 255));
               end
            endcase
            send_cmd(CMD_SCROLL, rnd8(), rnd8(), rnd8(), rnd8(), cnt);
         end
         sent += len;
      end
   endtask

   // response side: random stalls plus the odd long hold-off to back the block up
   initial begin : reply_sink
      int next_hold;
      next_hold = 350;
      forever begin
         if (!quiet_tail && shadow.replies_seen >= next_hold) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            next_hold += 400;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : reply_monitor
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            observed = '{rsp_if.cell_data, rsp_if.current_row, rsp_if.current_column,
                         rsp_if.bounds_error};
            shadow.check_reply(observed);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] palette [PHASES];
      int                phase;
      palette = '{8'h00, 8'hFF, rnd8(), 8'h01, rnd8(), 8'h1E};
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.command       <= CMD_PUT_CHAR;
      req_if.char_code     <= '0;
      req_if.cell_color    <= '0;
      req_if.target_column <= '0;
      req_if.target_row    <= '0;
      req_if.scroll_count  <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.text_color    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first phase runs on the reset colour
      directed_checks();
      drain();
      for (phase = 0; phase < PHASES; phase++) begin
         write_color(palette[phase]);
         if (phase == PHASES - 1) begin
            quiet_tail = 1'b1;
         end
         random_batch(BATCH_ITEMS);
         drain();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
